// ===== src/rbs_pkg.sv =====
// Shared types and constants of the reconnect backoff supervisor.
// Used by the front decoder, the item queue and the back state machine.
package rbs_pkg;

   localparam int STATION_W = 16;
   localparam int TIME_W    = 32;
   localparam int DELAY_W   = 20;
   localparam int COUNT_W   = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] MODE_IDLE         = 2'd0;
   localparam logic [1:0] MODE_CONNECTING   = 2'd1;
   localparam logic [1:0] MODE_PLAYING      = 2'd2;
   localparam logic [1:0] MODE_RECONNECTING = 2'd3;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_PLAY   = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_RESULT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_RETRY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_GRACE  = 2'd2;

   localparam logic [DELAY_W-1:0] FIRST_RETRY_RESET = 20'd1000;
   localparam logic [DELAY_W-1:0] MAX_RETRY_RESET   = 20'd30000;
   localparam logic [DELAY_W-1:0] DROP_GRACE_RESET  = 20'd2000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCOUNT_W    = 2;

   typedef struct packed {
      logic                 is_tick;
      logic                 is_play;
      logic                 is_stop;
      logic                 is_result;
      logic [TIME_W-1:0]    now_ms;
      logic [STATION_W-1:0] station;
      logic                 connect_ok;
      logic                 stream_running;
   } work_item_type;

endpackage

// ===== src/reconnect_backoff_supervisor.sv =====
// Top level of the reconnect backoff supervisor.
// Depends on rbs_pkg, rbs_front, rbs_queue and rbs_back.

// The supervisor takes one command item per cycle while the input is not stalled
// (tick, play, stop or connect result, each with a millisecond timestamp) and
// returns exactly one result item per command, in order, holding the link state
// after the command, the connect and teardown requests, the desired station and
// the three wrapping counters. An item passes the decoder, waits in a two-entry
// queue and is carried out by the state machine, which registers the result; the
// sustained rate is one item per cycle while the result is not stalled. While a
// result is stalled the queue holds up to two further items before the input
// stalls. Registers are written through the csr port, which is always ready, and
// should only be changed while no item is in flight.
module reconnect_backoff_supervisor
   import rbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic [STATION_W-1:0]   req_station,
   input  logic                   req_connect_ok,
   input  logic                   req_stream_running,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_link_state,
   output logic                   rsp_connect_request,
   output logic [STATION_W-1:0]   rsp_connect_station,
   output logic                   rsp_stop_stream,
   output logic [COUNT_W-1:0]     rsp_attempt_count,
   output logic [COUNT_W-1:0]     rsp_failure_count,
   output logic [COUNT_W-1:0]     rsp_drop_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DELAY_W-1:0]     csr_data
);

   logic          queue_full;
   logic          push_valid;
   work_item_type push_item;
   logic          pop_valid;
   work_item_type pop_item;
   logic          pop_take;

   assign csr_ready = 1'b1;

   rbs_front u_front (
      .req_valid          (req_valid),
      .req_command        (req_command),
      .req_now_ms         (req_now_ms),
      .req_station        (req_station),
      .req_connect_ok     (req_connect_ok),
      .req_stream_running (req_stream_running),
      .queue_full         (queue_full),
      .req_stall          (req_stall),
      .push_valid         (push_valid),
      .push_item          (push_item)
   );

   rbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_take   (pop_take)
   );

   rbs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_item            (pop_item),
      .pop_take            (pop_take),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_link_state      (rsp_link_state),
      .rsp_connect_request (rsp_connect_request),
      .rsp_connect_station (rsp_connect_station),
      .rsp_stop_stream     (rsp_stop_stream),
      .rsp_attempt_count   (rsp_attempt_count),
      .rsp_failure_count   (rsp_failure_count),
      .rsp_drop_count      (rsp_drop_count)
   );

endmodule

// ===== src/rbs_front.sv =====
// Front end: accepts request items and classifies the command into one-hot flags.
// Depends on rbs_pkg; feeds rbs_queue.
module rbs_front
   import rbs_pkg::*;
(
   input  logic                 req_valid,
   input  logic [1:0]           req_command,
   input  logic [TIME_W-1:0]    req_now_ms,
   input  logic [STATION_W-1:0] req_station,
   input  logic                 req_connect_ok,
   input  logic                 req_stream_running,
   input  logic                 queue_full,
   output logic                 req_stall,
   output logic                 push_valid,
   output work_item_type        push_item
);

   always_comb begin
      push_item                = '0;
      push_item.now_ms         = req_now_ms;
      push_item.station        = req_station;
      push_item.connect_ok     = req_connect_ok;
      push_item.stream_running = req_stream_running;
      case (req_command)
         CMD_TICK:   push_item.is_tick   = 1'b1;
         CMD_PLAY:   push_item.is_play   = 1'b1;
         CMD_STOP:   push_item.is_stop   = 1'b1;
         CMD_RESULT: push_item.is_result = 1'b1;
         default:    push_item.is_tick   = 1'b1;
      endcase
   end

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

endmodule

// ===== src/rbs_queue.sv =====
// Short queue of classified items between the front end and the back end.
// Depends on rbs_pkg.
module rbs_queue
   import rbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  work_item_type push_item,
   output logic          full,
   output logic          pop_valid,
   output work_item_type pop_item,
   input  logic          pop_take
);

   work_item_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_take && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/rbs_back.sv =====
// Back end: link state machine with exponential backoff, counters and result register.
// Depends on rbs_pkg; takes items from rbs_queue.
module rbs_back
   import rbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  work_item_type          pop_item,
   output logic                   pop_take,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DELAY_W-1:0]     csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_link_state,
   output logic                   rsp_connect_request,
   output logic [STATION_W-1:0]   rsp_connect_station,
   output logic                   rsp_stop_stream,
   output logic [COUNT_W-1:0]     rsp_attempt_count,
   output logic [COUNT_W-1:0]     rsp_failure_count,
   output logic [COUNT_W-1:0]     rsp_drop_count
);

   logic [DELAY_W-1:0]   first_retry_ff, max_retry_ff, drop_grace_ff;
   logic [1:0]           mode_ff, mode_in;
   logic [STATION_W-1:0] station_ff, station_in;
   logic [TIME_W-1:0]    retry_time_ff, retry_time_in;
   logic [DELAY_W-1:0]   next_delay_ff, next_delay_in;
   logic [TIME_W-1:0]    playing_since_ff, playing_since_in;
   logic [COUNT_W-1:0]   attempts_ff, attempts_in;
   logic [COUNT_W-1:0]   failures_ff, failures_in;
   logic [COUNT_W-1:0]   drops_ff, drops_in;
   logic                 req_ff, req_in;
   logic                 stop_ff, stop_in;
   logic                 valid_ff, valid_in;

   logic                 take;
   logic [TIME_W-1:0]    since_play;
   logic [TIME_W-1:0]    since_retry;
   logic [DELAY_W:0]     doubled;
   logic [DELAY_W-1:0]   backoff;
   logic                 drop_seen;
   logic                 retry_due;
   logic                 do_retry;
   logic                 do_connect;

   assign take     = pop_valid && (!valid_ff || !rsp_stall);
   assign pop_take = take;

   assign since_play  = pop_item.now_ms - playing_since_ff;
   assign since_retry = pop_item.now_ms - retry_time_ff;
   assign doubled     = {next_delay_ff, 1'b0};
   assign backoff     = (doubled > {1'b0, max_retry_ff}) ? max_retry_ff
                                                         : doubled[DELAY_W-1:0];
   assign drop_seen   = pop_item.is_tick && (mode_ff == MODE_PLAYING)
                        && !pop_item.stream_running
                        && (since_play >= {{(TIME_W-DELAY_W){1'b0}}, drop_grace_ff});
   assign retry_due   = pop_item.is_tick && (mode_ff == MODE_RECONNECTING)
                        && !since_retry[TIME_W-1];
   assign do_retry    = drop_seen || (pop_item.is_result && (mode_ff == MODE_CONNECTING)
                                      && !pop_item.connect_ok);
   assign do_connect  = retry_due || pop_item.is_play;

   always_comb begin
      mode_in          = mode_ff;
      station_in       = station_ff;
      retry_time_in    = retry_time_ff;
      next_delay_in    = next_delay_ff;
      playing_since_in = playing_since_ff;
      attempts_in      = attempts_ff;
      failures_in      = failures_ff;
      drops_in         = drops_ff;
      req_in           = req_ff;
      stop_in          = stop_ff;
      valid_in         = valid_ff && rsp_stall;
      if (take) begin
         valid_in = 1'b1;
         req_in   = do_connect;
         stop_in  = do_connect || pop_item.is_stop;
         if (do_connect) begin
            mode_in     = MODE_CONNECTING;
            attempts_in = attempts_ff + 1'b1;
         end
         if (pop_item.is_play) begin
            station_in    = pop_item.station;
            next_delay_in = first_retry_ff;
         end
         if (pop_item.is_stop) begin
            station_in = '0;
            mode_in    = MODE_IDLE;
         end
         if (drop_seen) begin
            drops_in = drops_ff + 1'b1;
         end
         if (pop_item.is_result && (mode_ff == MODE_CONNECTING)) begin
            if (pop_item.connect_ok) begin
               mode_in          = MODE_PLAYING;
               playing_since_in = pop_item.now_ms;
               next_delay_in    = first_retry_ff;
            end else begin
               failures_in = failures_ff + 1'b1;
            end
         end
         if (do_retry) begin
            mode_in       = MODE_RECONNECTING;
            retry_time_in = pop_item.now_ms + {{(TIME_W-DELAY_W){1'b0}}, next_delay_ff};
            next_delay_in = backoff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_retry_ff <= FIRST_RETRY_RESET;
         max_retry_ff   <= MAX_RETRY_RESET;
         drop_grace_ff  <= DROP_GRACE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FIRST_RETRY: first_retry_ff <= csr_data;
            CSR_MAX_RETRY:   max_retry_ff   <= csr_data;
            CSR_DROP_GRACE:  drop_grace_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         station_ff       <= '0;
         retry_time_ff    <= '0;
         next_delay_ff    <= FIRST_RETRY_RESET;
         playing_since_ff <= '0;
         attempts_ff      <= '0;
         failures_ff      <= '0;
         drops_ff         <= '0;
         req_ff           <= 1'b0;
         stop_ff          <= 1'b0;
         valid_ff         <= 1'b0;
      end else begin
         mode_ff          <= mode_in;
         station_ff       <= station_in;
         retry_time_ff    <= retry_time_in;
         next_delay_ff    <= next_delay_in;
         playing_since_ff <= playing_since_in;
         attempts_ff      <= attempts_in;
         failures_ff      <= failures_in;
         drops_ff         <= drops_in;
         req_ff           <= req_in;
         stop_ff          <= stop_in;
         valid_ff         <= valid_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_link_state      = mode_ff;
   assign rsp_connect_request = req_ff;
   assign rsp_connect_station = station_ff;
   assign rsp_stop_stream     = stop_ff;
   assign rsp_attempt_count   = attempts_ff;
   assign rsp_failure_count   = failures_ff;
   assign rsp_drop_count      = drops_ff;

endmodule
